// ===== src/qdd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types and constants of the quadrature dial decoder.
// ----------------------------------------------------------------------------
package qdd_pkg;

	localparam int unsigned TICKS_PER_SECOND = 1000000;
	localparam int unsigned RESYNC_TICKS     = 500000;

	localparam int unsigned SPEED_W = 20;
	localparam int unsigned CNT_W   = $clog2(SPEED_W);
	localparam logic [SPEED_W-1:0] TPS_VEC = SPEED_W'(TICKS_PER_SECOND);
	localparam logic [31:0] TPS_32    = 32'(TICKS_PER_SECOND);
	localparam logic [31:0] RESYNC_32 = 32'(RESYNC_TICKS);

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REG_DIVIDER      = 2'd0;
	localparam logic [1:0] REG_RANGE_ENABLE = 2'd1;
	localparam logic [1:0] REG_RANGE_MIN    = 2'd2;
	localparam logic [1:0] REG_RANGE_MAX    = 2'd3;

	localparam logic [1:0] MOVE_NONE = 2'd0;
	localparam logic [1:0] MOVE_UP   = 2'd1;
	localparam logic [1:0] MOVE_DOWN = 2'd2;

	localparam logic [1:0] STEP_NONE   = 2'd0;
	localparam logic [1:0] STEP_CW     = 2'd1;
	localparam logic [1:0] STEP_DOUBLE = 2'd2;

	typedef struct packed {
		logic        write;
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic        thresh;
		logic        up;
		logic        cw;
		logic        skp;
		logic [31:0] ts;
	} job_t;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} bk_state_t;

endpackage

// ===== src/qdd_front.sv =====
// ----------------------------------------------------------------------------
// qdd_front
// Takes encoder events, tracks the Gray code and the sub-counter, and
// hands one classified job per event to the job queue.
// ----------------------------------------------------------------------------
module qdd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  qdd_pkg::cfg_wr_t  cfg,
	input  logic              push,
	input  logic              q_full,
	input  logic              level_a,
	input  logic              level_b,
	input  logic [31:0]       timestamp,
	output logic              enq,
	output qdd_pkg::job_t     job
);

	logic [7:0]        divider_q;
	logic [1:0]        last_gray_q;
	logic              primed_q;
	logic signed [8:0] sub_q;
	logic [31:0]       last_ev_q;

	logic [1:0]        gray;
	logic [1:0]        step;
	logic [7:0]        div_eff;
	logic [31:0]       gap;
	logic              resync;
	logic signed [9:0] sub_base;
	logic signed [9:0] sub_step;
	logic signed [9:0] div_s;
	logic              moving;
	logic              thresh;

	assign enq = push && !q_full;

	always_comb begin
		gray     = {level_b, level_a ^ level_b};
		step     = gray - last_gray_q;
		div_eff  = (divider_q == 8'd0) ? 8'd1 : divider_q;
		gap      = timestamp - last_ev_q;
		resync   = (div_eff > 8'd1) && (sub_q != 9'sd0) && (gap > qdd_pkg::RESYNC_32);
		sub_base = resync ? 10'sd0 : 10'(sub_q);
		moving   = (step != qdd_pkg::STEP_NONE) && (step != qdd_pkg::STEP_DOUBLE);
		sub_step = (step == qdd_pkg::STEP_CW) ? sub_base + 10'sd1 : sub_base - 10'sd1;
		div_s    = signed'({2'b00, div_eff});
		thresh   = moving && primed_q && ((sub_step >= div_s) || (-sub_step >= div_s));

		job.thresh = thresh;
		job.up     = !sub_step[9];
		job.cw     = primed_q && (step == qdd_pkg::STEP_CW);
		job.skp    = primed_q && (step == qdd_pkg::STEP_DOUBLE);
		job.ts     = timestamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q   <= 8'd1;
			last_gray_q <= 2'd0;
			primed_q    <= 1'b0;
			sub_q       <= 9'sd0;
			last_ev_q   <= 32'd0;
		end else begin
			if (cfg.write && cfg.index == qdd_pkg::REG_DIVIDER) begin
				divider_q <= cfg.data[7:0];
			end
			if (enq) begin
				last_gray_q <= gray;
				if (!primed_q) begin
					primed_q <= 1'b1;
				end else begin
					last_ev_q <= timestamp;
					if (thresh) begin
						sub_q <= 9'sd0;
					end else if (moving) begin
						sub_q <= sub_step[8:0];
					end else begin
						sub_q <= sub_base[8:0];
					end
				end
			end
		end
	end

endmodule

// ===== src/qdd_queue.sv =====
// ----------------------------------------------------------------------------
// qdd_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module qdd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           enq,
	input  qdd_pkg::job_t  enq_job,
	input  logic           deq,
	output logic           full,
	output logic           avail,
	output qdd_pkg::job_t  head_job
);

	qdd_pkg::job_t                    entry_q [qdd_pkg::QUEUE_DEPTH];
	logic [qdd_pkg::QPTR_W-1:0]       head_q;
	logic [qdd_pkg::QPTR_W-1:0]       tail_q;
	logic [qdd_pkg::QCNT_W-1:0]       count_q;

	assign full     = (count_q == qdd_pkg::QCNT_W'(qdd_pkg::QUEUE_DEPTH));
	assign avail    = (count_q != '0);
	assign head_job = entry_q[head_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[tail_q] <= enq_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (enq) begin
				tail_q <= (tail_q == qdd_pkg::QPTR_W'(qdd_pkg::QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (deq) begin
				head_q <= (head_q == qdd_pkg::QPTR_W'(qdd_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/qdd_back.sv =====
// ----------------------------------------------------------------------------
// qdd_back
// Carries out jobs: position move with range limits, speed estimate by a
// bit-serial divider (or set directly for a zero or over-long gap), and the result register.
// ----------------------------------------------------------------------------
module qdd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qdd_pkg::cfg_wr_t              cfg,
	input  logic                          avail,
	input  qdd_pkg::job_t                 head_job,
	output logic                          deq,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [31:0]            position,
	output logic [1:0]                    move,
	output logic                          step_clockwise,
	output logic                          blocked,
	output logic                          skipped,
	output logic [qdd_pkg::SPEED_W-1:0]   speed
);

	qdd_pkg::bk_state_t state_q, state_d;

	logic                         range_en_q;
	logic signed [31:0]           range_min_q;
	logic signed [31:0]           range_max_q;
	logic signed [31:0]           pos_q;
	logic [31:0]                  last_move_q;
	logic [qdd_pkg::SPEED_W-1:0]  speed_q;
	logic                         out_valid_q;

	logic [qdd_pkg::SPEED_W-1:0]  diff_q;
	logic [qdd_pkg::SPEED_W-1:0]  rem_q;
	logic [qdd_pkg::SPEED_W-1:0]  quo_q;
	logic [qdd_pkg::CNT_W-1:0]    cnt_q;

	logic                         out_free;
	logic [31:0]                  diff;
	logic                         blk;
	logic [qdd_pkg::SPEED_W:0]    rem_sh;
	logic                         rem_ge;
	logic                         div_done;
	logic                         take_direct;

	assign empty    = !out_valid_q;
	assign out_free = !out_valid_q || pop;
	assign speed    = speed_q;

	always_comb begin
		diff   = head_job.ts - last_move_q;
		blk    = range_en_q && (head_job.up ? (pos_q >= range_max_q) : (pos_q <= range_min_q));
		rem_sh = {rem_q, qdd_pkg::TPS_VEC[cnt_q]};
		rem_ge = rem_sh >= {1'b0, diff_q};
		div_done = (state_q == qdd_pkg::BK_DIV) && (cnt_q == '0);

		state_d     = state_q;
		deq         = 1'b0;
		take_direct = 1'b0;
		case (state_q)
			qdd_pkg::BK_IDLE: begin
				if (avail && out_free) begin
					deq = 1'b1;
					if (head_job.thresh && diff <= qdd_pkg::TPS_32 && diff != 32'd0) begin
						state_d = qdd_pkg::BK_DIV;
					end else begin
						take_direct = 1'b1;
					end
				end
			end
			qdd_pkg::BK_DIV: begin
				if (cnt_q == '0) begin
					state_d = qdd_pkg::BK_IDLE;
				end
			end
			default: state_d = qdd_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qdd_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// arithmetic and result state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_en_q  <= 1'b0;
			range_min_q <= 32'sh8000_0000;
			range_max_q <= 32'sh7fff_ffff;
			pos_q       <= 32'sd0;
			last_move_q <= 32'd0;
			speed_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg.write) begin
				case (cfg.index)
					qdd_pkg::REG_RANGE_ENABLE: begin
						range_en_q <= cfg.data[0];
						if (cfg.data[0]) begin
							if (range_min_q > pos_q) begin
								pos_q <= range_min_q;
							end else if (range_max_q < pos_q) begin
								pos_q <= range_max_q;
							end
						end
					end
					qdd_pkg::REG_RANGE_MIN: range_min_q <= signed'(cfg.data);
					qdd_pkg::REG_RANGE_MAX: range_max_q <= signed'(cfg.data);
					default: ;
				endcase
			end

			out_valid_q <= (out_valid_q && !pop) || take_direct || div_done;

			if (deq) begin
				if (head_job.thresh) begin
					if (!blk) begin
						pos_q       <= head_job.up ? pos_q + 32'sd1 : pos_q - 32'sd1;
						last_move_q <= head_job.ts;
					end
					if (diff > qdd_pkg::TPS_32) begin
						speed_q <= qdd_pkg::SPEED_W'(1);
					end else if (diff == 32'd0) begin
						speed_q <= qdd_pkg::TPS_VEC;
					end
				end
				cnt_q <= qdd_pkg::CNT_W'(qdd_pkg::SPEED_W - 1);
			end else if (state_q == qdd_pkg::BK_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end

			if (div_done) begin
				speed_q <= {quo_q[qdd_pkg::SPEED_W-2:0], rem_ge};
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (deq) begin
			move           <= (head_job.thresh && !blk) ?
				(head_job.up ? qdd_pkg::MOVE_UP : qdd_pkg::MOVE_DOWN) : qdd_pkg::MOVE_NONE;
			step_clockwise <= head_job.cw;
			blocked        <= head_job.thresh && blk;
			skipped        <= head_job.skp;
			diff_q         <= diff[qdd_pkg::SPEED_W-1:0];
			rem_q          <= '0;
			quo_q          <= '0;
		end else if (state_q == qdd_pkg::BK_DIV) begin
			rem_q <= rem_ge ? qdd_pkg::SPEED_W'(rem_sh - {1'b0, diff_q})
				: rem_sh[qdd_pkg::SPEED_W-1:0];
			quo_q <= {quo_q[qdd_pkg::SPEED_W-2:0], rem_ge};
		end
	end

	assign position = pos_q;

endmodule

// ===== src/quadrature_dial_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// quadrature_dial_decoder_unit
// Quadrature rotary dial decoder: Gray step tracking, divided position with
// optional range limits, and a moves-per-second speed estimate.
//
//   channel   handshake        payload
//   input     push / full      level_a, level_b, timestamp
//   result    empty / pop      position, move, step_clockwise, blocked,
//                              skipped, speed
//   config    cfg_write        cfg_index, cfg_data
//
// The front takes an event every cycle while the two-entry job queue has room.
// The back retires a job directly, or, when the position threshold is hit and
// the speed needs the 20-step bit-serial divider, once the divider has finished.
// A result waits in the result register; the back stalls while it is held
// and the queue absorbs up to two further events. Reset is asynchronous and
// clears all but the payload and queue data registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quadrature_dial_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic                          level_a,
	input  logic                          level_b,
	input  logic [31:0]                   timestamp,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [31:0]            position,
	output logic [1:0]                    move,
	output logic                          step_clockwise,
	output logic                          blocked,
	output logic                          skipped,
	output logic [qdd_pkg::SPEED_W-1:0]   speed
);

	qdd_pkg::cfg_wr_t cfg;
	qdd_pkg::job_t    enq_job;
	qdd_pkg::job_t    head_job;
	logic             enq;
	logic             deq;
	logic             avail;

	assign cfg.write = cfg_write;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	qdd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.q_full    (full),
		.level_a   (level_a),
		.level_b   (level_b),
		.timestamp (timestamp),
		.enq       (enq),
		.job       (enq_job)
	);

	qdd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_job  (enq_job),
		.deq      (deq),
		.full     (full),
		.avail    (avail),
		.head_job (head_job)
	);

	qdd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.avail          (avail),
		.head_job       (head_job),
		.deq            (deq),
		.pop            (pop),
		.empty          (empty),
		.position       (position),
		.move           (move),
		.step_clockwise (step_clockwise),
		.blocked        (blocked),
		.skipped        (skipped),
		.speed          (speed)
	);

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrature dial decoder. A short table of
// directed events and register writes comes first, then phases of random
// encoder rotation under changing divider and range settings. Every result
// is checked against the in-bench model or a typed row's expectation, with
// random stalls on both queue sides, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 5;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int PHASES        = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 25;
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic signed [31:0]           position;
		logic [1:0]                   move;
		logic                         cw;
		logic                         blk;
		logic                         skp;
		logic [qdd_pkg::SPEED_W-1:0]  speed;
	} dial_reading_t;

	typedef enum logic {
		ROW_EVENT,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		bit            a;
		bit            b;
		logic [31:0]   ts;
		logic [1:0]    idx;
		logic [31:0]   data;
		bit            typed;
		dial_reading_t exp;
	} stim_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_write;
	logic [1:0]                   cfg_index;
	logic [31:0]                  cfg_data;
	logic                         push;
	logic                         full;
	logic                         level_a;
	logic                         level_b;
	logic [31:0]                  timestamp;
	logic                         empty;
	logic                         pop;
	logic signed [31:0]           position;
	logic [1:0]                   move;
	logic                         step_clockwise;
	logic                         blocked;
	logic                         skipped;
	logic [qdd_pkg::SPEED_W-1:0]  speed;

	// model state
	logic [7:0]                   divider_q;
	bit                           range_en_q;
	logic signed [31:0]           range_min_q;
	logic signed [31:0]           range_max_q;
	logic [1:0]                   gray_q;
	bit                           primed_q;
	int                           sub_q;
	logic signed [31:0]           pos_q;
	logic [31:0]                  event_time_q;
	logic [31:0]                  move_time_q;
	logic [qdd_pkg::SPEED_W-1:0]  speed_q;

	dial_reading_t        awaited_readings[$];
	stim_row_t            directed_rows[$];
	bit                   row_typed;
	dial_reading_t        row_expect;
	bit                   tx_calm;
	bit                   rx_calm;
	bit                   hold_request;

	int                   mismatches;
	int                   cycle_count;
	int                   n_events;
	int                   n_moves;
	int                   n_blocked;
	int                   n_skipped;
	int                   n_writes;
	int                   n_stall_cycles;

	always #(HALF_PERIOD) clk = ~clk;

	quadrature_dial_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.level_a        (level_a),
		.level_b        (level_b),
		.timestamp      (timestamp),
		.empty          (empty),
		.pop            (pop),
		.position       (position),
		.move           (move),
		.step_clockwise (step_clockwise),
		.blocked        (blocked),
		.skipped        (skipped),
		.speed          (speed)
	);

	function automatic void apply_register(logic [1:0] idx, logic [31:0] data);
		case (idx)
			qdd_pkg::REG_DIVIDER: begin
				divider_q = data[7:0];
			end
			qdd_pkg::REG_RANGE_ENABLE: begin
				range_en_q = data[0];
				if (range_en_q) begin
					if (range_min_q > pos_q)
						pos_q = range_min_q;
					else if (range_max_q < pos_q)
						pos_q = range_max_q;
				end
			end
			qdd_pkg::REG_RANGE_MIN: begin
				range_min_q = data;
			end
			default: begin
				range_max_q = data;
			end
		endcase
	endfunction

	function automatic dial_reading_t advance_dial(bit a, bit b, logic [31:0] ts);
		dial_reading_t r;
		logic [1:0]    g;
		logic [1:0]    d;
		int            limit;
		logic [31:0]   since;
		bit            up;
		r = '0;
		g = {b, a ^ b};
		limit = (divider_q == 8'd0) ? 1 : int'(divider_q);
		if (!primed_q) begin
			primed_q = 1'b1;
			gray_q = g;
		end else begin
			d = g - gray_q;
			gray_q = g;
			// stale partial count is dropped before the new step
			if (limit > 1 && sub_q != 0 && (ts - event_time_q) > qdd_pkg::RESYNC_32)
				sub_q = 0;
			event_time_q = ts;
			if (d == qdd_pkg::STEP_DOUBLE) begin
				r.skp = 1'b1;
			end else if (d != qdd_pkg::STEP_NONE) begin
				if (d == qdd_pkg::STEP_CW) begin
					r.cw = 1'b1;
					sub_q++;
				end else begin
					sub_q--;
				end
				if (sub_q >= limit || -sub_q >= limit) begin
					since = ts - move_time_q;
					up = sub_q > 0;
					if (since > qdd_pkg::TPS_32)
						speed_q = 1;
					else if (since == 32'd0)
						speed_q = qdd_pkg::TPS_VEC;
					else
						speed_q = qdd_pkg::SPEED_W'(qdd_pkg::TPS_32 / since);
					sub_q = 0;
					if (up) begin
						if (range_en_q && pos_q >= range_max_q) begin
							r.blk = 1'b1;
						end else begin
							pos_q = pos_q + 32'sd1;
							r.move = qdd_pkg::MOVE_UP;
						end
					end else begin
						if (range_en_q && pos_q <= range_min_q) begin
							r.blk = 1'b1;
						end else begin
							pos_q = pos_q - 32'sd1;
							r.move = qdd_pkg::MOVE_DOWN;
						end
					end
					if (!r.blk)
						move_time_q = ts;
				end
			end
		end
		r.position = pos_q;
		r.speed = speed_q;
		return r;
	endfunction

	function automatic dial_reading_t reading(logic signed [31:0] p, logic [1:0] m, bit c,
			bit bl, bit sk, logic [qdd_pkg::SPEED_W-1:0] s);
		dial_reading_t r;
		r.position = p;
		r.move = m;
		r.cw = c;
		r.blk = bl;
		r.skp = sk;
		r.speed = s;
		return r;
	endfunction

	function automatic void add_event(bit a, bit b, logic [31:0] ts, bit typed = 0,
			dial_reading_t exp = '0);
		stim_row_t row;
		row.kind = ROW_EVENT;
		row.a = a;
		row.b = b;
		row.ts = ts;
		row.idx = qdd_pkg::REG_DIVIDER;
		row.data = '0;
		row.typed = typed;
		row.exp = exp;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic void add_write(logic [1:0] idx, logic [31:0] data);
		stim_row_t row;
		row.kind = ROW_WRITE;
		row.a = 0;
		row.b = 0;
		row.ts = '0;
		row.idx = idx;
		row.data = data;
		row.typed = 0;
		row.exp = '0;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	task automatic offer_event(bit a, bit b, logic [31:0] ts, bit typed, dial_reading_t exp);
		int gap;
		gap = pick_gap(tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		level_a <= a;
		level_b <= b;
		timestamp <= ts;
		row_typed = typed;
		row_expect = exp;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (awaited_readings.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		apply_register(idx, data);
		n_writes++;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// result side: random pop gaps plus one long hold-off on request
	initial begin : result_side
		int gap;
		int held;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				pop <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
				hold_request = 0;
			end else begin
				gap = pick_gap(rx_calm);
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		dial_reading_t got;
		dial_reading_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("quadrature_dial_decoder_unit: mismatch");
			$finish;
		end else if (arst_n) begin
			if (pop && !empty) begin
				got = reading(position, move, step_clockwise, blocked, skipped, speed);
				if (awaited_readings.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected transfer: position %0d move %0d", position, move);
				end else begin
					want = awaited_readings.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("bad reading (got/exp): position %0d/%0d move %0d/%0d",
								got.position, want.position, got.move, want.move);
							$display("  cw %0b/%0b blocked %0b/%0b skipped %0b/%0b speed %0d/%0d",
								got.cw, want.cw, got.blk, want.blk, got.skp, want.skp,
								got.speed, want.speed);
						end
					end
				end
			end
			if (push && !full) begin
				want = advance_dial(level_a, level_b, timestamp);
				n_events++;
				if (want.move != qdd_pkg::MOVE_NONE)
					n_moves++;
				if (want.blk)
					n_blocked++;
				if (want.skp)
					n_skipped++;
				awaited_readings.insert(awaited_readings.size(),
					row_typed ? row_expect : want);
			end
			if (push && full)
				n_stall_cycles++;
		end
	end

	initial begin : stimulus
		logic [31:0]        ts_now;
		logic [1:0]         drive_gray;
		bit                 dir_cw;
		int                 per_phase;
		int                 r;
		logic [7:0]         div;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		bit                 en;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = qdd_pkg::REG_DIVIDER;
		cfg_data = '0;
		push = 1'b0;
		level_a = 1'b0;
		level_b = 1'b0;
		timestamp = '0;
		row_typed = 0;
		row_expect = '0;
		tx_calm = 1;
		rx_calm = 1;
		hold_request = 0;

		divider_q = 8'd1;
		range_en_q = 0;
		range_min_q = 32'sh80000000;
		range_max_q = 32'sh7FFFFFFF;
		gray_q = 2'd0;
		primed_q = 0;
		sub_q = 0;
		pos_q = '0;
		event_time_q = '0;
		move_time_q = '0;
		speed_q = '0;

		// first event only primes, first step at zero elapsed time saturates speed
		add_event(0, 0, 32'd0, 1, reading(0, qdd_pkg::MOVE_NONE, 0, 0, 0, 0));
		add_event(1, 0, 32'd0, 1, reading(1, qdd_pkg::MOVE_UP, 1, 0, 0, 20'd1000000));
		add_event(1, 1, 32'd1000000);
		add_event(1, 1, 32'd1000001);
		add_event(0, 0, 32'd1000002);
		add_event(0, 1, 32'd1000003);
		add_event(0, 0, 32'hFFFFFFFF);
		add_event(1, 0, 32'h00000010);
		// clamp to the top, block there, then wrap upward with limits off
		add_write(qdd_pkg::REG_RANGE_MIN, 32'h7FFFFFFF);
		add_write(qdd_pkg::REG_RANGE_MAX, 32'h7FFFFFFF);
		add_write(qdd_pkg::REG_RANGE_ENABLE, 32'd1);
		add_event(1, 1, 32'd3000016, 1,
			reading(32'sh7FFFFFFF, qdd_pkg::MOVE_NONE, 1, 1, 0, 1));
		add_write(qdd_pkg::REG_RANGE_ENABLE, 32'd0);
		add_event(0, 1, 32'd6000016, 1,
			reading(32'sh80000000, qdd_pkg::MOVE_UP, 1, 0, 0, 1));
		add_write(qdd_pkg::REG_RANGE_MIN, 32'h80000000);
		add_write(qdd_pkg::REG_RANGE_MAX, 32'h80000000);
		add_write(qdd_pkg::REG_RANGE_ENABLE, 32'd1);
		add_event(1, 1, 32'd9000016, 1,
			reading(32'sh80000000, qdd_pkg::MOVE_NONE, 0, 1, 0, 1));
		add_write(qdd_pkg::REG_RANGE_ENABLE, 32'd0);
		add_event(1, 0, 32'd12000016, 1,
			reading(32'sh7FFFFFFF, qdd_pkg::MOVE_DOWN, 0, 0, 0, 1));
		add_write(qdd_pkg::REG_RANGE_MAX, 32'h7FFFFFFF);
		add_write(qdd_pkg::REG_DIVIDER, 32'd0);
		add_event(0, 0, 32'd12000017);
		add_event(1, 0, 32'd12000019);
		// divide by three with a resync gap in the middle
		add_write(qdd_pkg::REG_DIVIDER, 32'd3);
		add_event(1, 1, 32'd12000100);
		add_event(0, 1, 32'd12000200);
		add_event(0, 0, 32'd12600300);
		add_event(1, 0, 32'd12600301);
		add_event(1, 1, 32'd12600302);
		add_event(1, 1, 32'd12600303);
		add_write(qdd_pkg::REG_DIVIDER, 32'd255);
		add_event(0, 1, 32'd13000000);
		// inverted range blocks both directions
		add_write(qdd_pkg::REG_DIVIDER, 32'd2);
		add_write(qdd_pkg::REG_RANGE_MIN, 32'd10);
		add_write(qdd_pkg::REG_RANGE_MAX, -32'sd10);
		add_write(qdd_pkg::REG_RANGE_ENABLE, 32'd1);
		add_event(0, 0, 32'd13000100);
		add_event(1, 0, 32'd13000200);
		add_event(0, 0, 32'd13000300);
		add_event(0, 1, 32'd13000400);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_register(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				offer_event(directed_rows[i].a, directed_rows[i].b, directed_rows[i].ts,
					directed_rows[i].typed, directed_rows[i].exp);
			end
		end

		ts_now = 32'd13000400 + $urandom_range(0, 1000);
		drive_gray = 2'd3;
		dir_cw = 1;
		per_phase = RANDOM_ITEMS / PHASES;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case ($urandom_range(0, 6))
				0: div = 8'd0;
				1: div = 8'd1;
				2: div = 8'd2;
				3: div = 8'd3;
				4: div = 8'd4;
				5: div = 8'($urandom_range(5, 16));
				default: div = 8'd255;
			endcase
			case ($urandom_range(0, 4))
				0: begin
					lo = $urandom;
					hi = $urandom;
					en = 0;
				end
				1: begin
					lo = pos_q - $urandom_range(0, 6);
					hi = pos_q + $urandom_range(0, 6);
					en = 1;
				end
				2: begin
					lo = pos_q + $urandom_range(0, 8) - 4;
					hi = lo;
					en = 1;
				end
				3: begin
					lo = pos_q + 3;
					hi = pos_q - 3;
					en = 1;
				end
				default: begin
					lo = 32'sh80000000;
					hi = 32'sh7FFFFFFF;
					en = 1;
				end
			endcase
			write_register(qdd_pkg::REG_DIVIDER, {24'd0, div});
			write_register(qdd_pkg::REG_RANGE_MIN, lo);
			write_register(qdd_pkg::REG_RANGE_MAX, hi);
			write_register(qdd_pkg::REG_RANGE_ENABLE, {31'd0, en});
			tx_calm = (phase == 0 || phase == 1) ? 1 : ($urandom_range(0, 4) == 0);
			rx_calm = (phase == 0) ? 1 : ($urandom_range(0, 4) == 0);
			if (phase == 2) begin
				tx_calm = 1;
				hold_request = 1;
			end
			for (int i = 0; i < per_phase; i++) begin
				if (phase == 4 && i == per_phase / 2)
					wait_idle();
				if ($urandom_range(0, 99) < 5)
					dir_cw = !dir_cw;
				r = $urandom_range(0, 99);
				if (r < 70)
					drive_gray = dir_cw ? drive_gray + 2'd1 : drive_gray - 2'd1;
				else if (r < 85 && r >= 80)
					drive_gray = drive_gray + 2'd2;
				else if (r >= 85)
					drive_gray = 2'($urandom);
				r = $urandom_range(0, 99);
				if (r < 10)
					ts_now = ts_now;
				else if (r < 60)
					ts_now = ts_now + $urandom_range(1, 50);
				else if (r < 85)
					ts_now = ts_now + $urandom_range(51, 200000);
				else if (r < 95)
					ts_now = ts_now + $urandom_range(400000, 1500000);
				else
					ts_now = $urandom;
				offer_event(drive_gray[0] ^ drive_gray[1], drive_gray[1], ts_now, 0, '0);
			end
		end

		wait_idle();
		$display("run covered %0d events: %0d moves, %0d blocked, %0d double steps",
			n_events, n_moves, n_blocked, n_skipped);
		$display("%0d register writes, %0d cycles with the input held off by a full queue",
			n_writes, n_stall_cycles);
		if (mismatches == 0 && awaited_readings.size() == 0)
			$display("quadrature_dial_decoder_unit: match");
		else
			$display("quadrature_dial_decoder_unit: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/qdd_pkg.sv
src/qdd_front.sv
src/qdd_queue.sv
src/qdd_back.sv
src/quadrature_dial_decoder_unit.sv
test/tb_top.sv
